### hdl/rarsf_pkg.sv
package rarsf_pkg;

    // Field widths of the request, response and size register
    localparam int IDX_W  = 13;
    localparam int VAL_W  = 32;
    localparam int SUM_W  = 64;
    localparam int UPC_W  = 6;

    localparam logic [IDX_W-1:0] SIZE_RST = IDX_W'(4096);

    // Request command codes
    localparam logic CMD_ADD = 1'b0;
    localparam logic CMD_SUM = 1'b1;

    typedef struct packed {
        logic                    command;
        logic [IDX_W-1:0]        left_index;
        logic [IDX_W-1:0]        right_index;
        logic signed [VAL_W-1:0] add_value;
    } t_req;

    typedef struct packed {
        logic signed [SUM_W-1:0] range_sum;
        logic                    range_error;
    } t_rsp;

    typedef struct packed {
        logic [IDX_W-1:0] size_in_use;
    } t_cfg;

    // Datapath operations, one per microcode step
    typedef enum logic [4:0] {
        OP_NOP,
        OP_CLEAR,
        OP_TAKE,
        OP_ADD_LEFT,
        OP_ADD_RIGHT,
        OP_MUL_LO,
        OP_MUL_HI,
        OP_AMT_LOAD,
        OP_UPD_RD,
        OP_UPD_WR,
        OP_SUM_HI,
        OP_SUM_LO,
        OP_QRY_RD,
        OP_QRY_ACC,
        OP_SET_MA,
        OP_SUM_FIRST,
        OP_SUM_SECOND,
        OP_SET_ERR,
        OP_EMIT
    } t_uop;

    // Jump conditions
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_REQ,
        C_CLR_MORE,
        C_ADD_BAD,
        C_RANGE_BAD,
        C_IS_SUM,
        C_POS_OUT,
        C_POS_ZERO,
        C_OUT_BUSY
    } t_cond;

    // Microcode step addresses
    typedef enum logic [UPC_W-1:0] {
        U_EMIT      = 6'd0,
        U_IDLE      = 6'd1,
        U_CHK_ADD   = 6'd2,
        U_CHK_SUM   = 6'd3,
        U_DISPATCH  = 6'd4,
        U_ADD_LEFT  = 6'd5,
        U_ADD_LMLO  = 6'd6,
        U_ADD_LMHI  = 6'd7,
        U_ADD_LAMT  = 6'd8,
        U_UPL_RD    = 6'd9,
        U_UPL_WR    = 6'd10,
        U_ADD_RIGHT = 6'd11,
        U_ADD_RMLO  = 6'd12,
        U_ADD_RMHI  = 6'd13,
        U_ADD_RAMT  = 6'd14,
        U_UPR_RD    = 6'd15,
        U_UPR_WR    = 6'd16,
        U_SUM_HI    = 6'd17,
        U_QH_RD     = 6'd18,
        U_QH_ACC    = 6'd19,
        U_QH_MA     = 6'd20,
        U_QH_MLO    = 6'd21,
        U_QH_MHI    = 6'd22,
        U_QH_FIN    = 6'd23,
        U_SUM_LO    = 6'd24,
        U_QL_RD     = 6'd25,
        U_QL_ACC    = 6'd26,
        U_QL_MA     = 6'd27,
        U_QL_MLO    = 6'd28,
        U_QL_MHI    = 6'd29,
        U_QL_FIN    = 6'd30,
        U_BAD_SUM   = 6'd31,
        U_CLEAR     = 6'd32,
        U_CLR_END   = 6'd33
    } t_upc;

    typedef struct packed {
        t_uop  op;
        t_cond cond;
        t_upc  target;
    } t_uword;

    // Status flags the datapath reports to the sequencer
    typedef struct packed {
        logic req_valid;
        logic clr_more;
        logic add_bad;
        logic range_bad;
        logic is_sum;
        logic pos_out;
        logic pos_zero;
        logic out_busy;
    } t_seq_stat;

    // Control program: taken condition jumps to target, else next step
    function automatic t_uword ucode_rom(input t_upc pc);
        t_uword w;
        w = '{OP_NOP, C_ALWAYS, U_IDLE};
        unique case (pc)
            U_EMIT:      w = '{OP_EMIT,       C_OUT_BUSY,  U_EMIT};
            U_IDLE:      w = '{OP_TAKE,       C_NO_REQ,    U_IDLE};
            U_CHK_ADD:   w = '{OP_NOP,        C_ADD_BAD,   U_IDLE};
            U_CHK_SUM:   w = '{OP_NOP,        C_RANGE_BAD, U_BAD_SUM};
            U_DISPATCH:  w = '{OP_NOP,        C_IS_SUM,    U_SUM_HI};
            U_ADD_LEFT:  w = '{OP_ADD_LEFT,   C_NEVER,     U_IDLE};
            U_ADD_LMLO:  w = '{OP_MUL_LO,     C_NEVER,     U_IDLE};
            U_ADD_LMHI:  w = '{OP_MUL_HI,     C_NEVER,     U_IDLE};
            U_ADD_LAMT:  w = '{OP_AMT_LOAD,   C_NEVER,     U_IDLE};
            U_UPL_RD:    w = '{OP_UPD_RD,     C_POS_OUT,   U_ADD_RIGHT};
            U_UPL_WR:    w = '{OP_UPD_WR,     C_ALWAYS,    U_UPL_RD};
            U_ADD_RIGHT: w = '{OP_ADD_RIGHT,  C_NEVER,     U_IDLE};
            U_ADD_RMLO:  w = '{OP_MUL_LO,     C_NEVER,     U_IDLE};
            U_ADD_RMHI:  w = '{OP_MUL_HI,     C_NEVER,     U_IDLE};
            U_ADD_RAMT:  w = '{OP_AMT_LOAD,   C_NEVER,     U_IDLE};
            U_UPR_RD:    w = '{OP_UPD_RD,     C_POS_OUT,   U_IDLE};
            U_UPR_WR:    w = '{OP_UPD_WR,     C_ALWAYS,    U_UPR_RD};
            U_SUM_HI:    w = '{OP_SUM_HI,     C_NEVER,     U_IDLE};
            U_QH_RD:     w = '{OP_QRY_RD,     C_POS_ZERO,  U_QH_MA};
            U_QH_ACC:    w = '{OP_QRY_ACC,    C_ALWAYS,    U_QH_RD};
            U_QH_MA:     w = '{OP_SET_MA,     C_NEVER,     U_IDLE};
            U_QH_MLO:    w = '{OP_MUL_LO,     C_NEVER,     U_IDLE};
            U_QH_MHI:    w = '{OP_MUL_HI,     C_NEVER,     U_IDLE};
            U_QH_FIN:    w = '{OP_SUM_FIRST,  C_NEVER,     U_IDLE};
            U_SUM_LO:    w = '{OP_SUM_LO,     C_NEVER,     U_IDLE};
            U_QL_RD:     w = '{OP_QRY_RD,     C_POS_ZERO,  U_QL_MA};
            U_QL_ACC:    w = '{OP_QRY_ACC,    C_ALWAYS,    U_QL_RD};
            U_QL_MA:     w = '{OP_SET_MA,     C_NEVER,     U_IDLE};
            U_QL_MLO:    w = '{OP_MUL_LO,     C_NEVER,     U_IDLE};
            U_QL_MHI:    w = '{OP_MUL_HI,     C_NEVER,     U_IDLE};
            U_QL_FIN:    w = '{OP_SUM_SECOND, C_ALWAYS,    U_EMIT};
            U_BAD_SUM:   w = '{OP_SET_ERR,    C_ALWAYS,    U_EMIT};
            U_CLEAR:     w = '{OP_CLEAR,      C_CLR_MORE,  U_CLEAR};
            U_CLR_END:   w = '{OP_NOP,        C_ALWAYS,    U_IDLE};
            default:     w = '{OP_NOP,        C_ALWAYS,    U_IDLE};
        endcase
        return w;
    endfunction

endpackage

### hdl/rarsf_chan_if.sv
interface rarsf_chan_if #(
    parameter type T_PAYLOAD = logic
);
    logic     valid;
    logic     ready;
    T_PAYLOAD payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### hdl/range_add_range_sum_fenwick.sv
// Range add / range sum store over DEPTH 64-bit elements, one-based.
// i_req takes a command: add add_value over [left_index, right_index],
// or ask for the sum over that range. Only a sum gives a response on
// o_rsp: range_sum and range_error (error when left_index is zero, the
// range is empty or it runs past size_in_use or DEPTH; the sum then
// reads zero). An add with a bad range is dropped. i_cfg writes
// size_in_use and is always ready. One request is worked at a time by a
// microcoded sequencer driving a shared 32 x 14 multiplier and two tree
// RAMs with registered reads. Each tree level is a read, then a write
// or an accumulate. An add walks both trees up from left_index and then
// from right_index + 1; a sum walks them down from right_index and then
// from left_index - 1. A dropped add goes straight back to idle; a sum
// with a bad range goes straight to its error response.
// After reset the trees are cleared, one entry a cycle, and i_req stays
// not ready until the pass is done. A response waits in its output
// register while o_rsp is stalled; the next request is still taken, and
// a sum holds at its emit step until the register frees up.
module range_add_range_sum_fenwick #(
    parameter int DEPTH = 4096
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rarsf_chan_if.sink   i_req,
    rarsf_chan_if.source o_rsp,
    rarsf_chan_if.sink   i_cfg
);
    import rarsf_pkg::*;

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int TREE_W = $clog2(DEPTH + 1) + 1;
    localparam int POS_W  = ((IDX_W + 1) > TREE_W) ? (IDX_W + 1) : TREE_W;
    localparam int HALF_W = SUM_W / 2;
    localparam int PROD_W = HALF_W + POS_W;
    localparam logic [POS_W-1:0] POS_DEPTH = POS_W'(DEPTH);

    t_uop             w_op;
    t_seq_stat        w_stat;

    logic [IDX_W-1:0] r_size;
    logic             r_cmd;
    logic             r_bad;
    logic [IDX_W-1:0] r_lo;
    logic [IDX_W-1:0] r_hi;
    logic [SUM_W-1:0] r_val;
    logic [POS_W-1:0] r_pos;
    logic [SUM_W-1:0] r_amt_s;
    logic [SUM_W-1:0] r_amt_o;
    logic [SUM_W-1:0] r_acc_s;
    logic [SUM_W-1:0] r_acc_o;
    logic [SUM_W-1:0] r_mul_a;
    logic [POS_W-1:0] r_mul_b;
    logic [SUM_W-1:0] r_prod;
    logic [SUM_W-1:0] r_result;
    logic             r_err;
    logic             r_out_valid;
    t_rsp             r_out;

    logic [POS_W-1:0]  w_lo_in;
    logic [POS_W-1:0]  w_hi_in;
    logic [POS_W-1:0]  w_size;
    logic [POS_W-1:0]  w_limit;
    logic              w_bad_in;
    logic [POS_W-1:0]  w_lo_ext;
    logic [POS_W-1:0]  w_hi_ext;
    logic [POS_W-1:0]  w_low_bit;
    logic [ADDR_W-1:0] w_addr;
    logic              w_we;
    logic [SUM_W-1:0]  w_wdata_s;
    logic [SUM_W-1:0]  w_wdata_o;
    logic [SUM_W-1:0]  w_rd_s;
    logic [SUM_W-1:0]  w_rd_o;
    logic [SUM_W-1:0]  w_neg_val;
    logic [HALF_W-1:0] w_mul_half;
    logic [PROD_W-1:0] w_mul_p;
    logic              w_emit;

    // Sequencer
    rarsf_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_op    (w_op)
    );

    // Range check of an incoming request
    always_comb begin
        w_lo_in  = POS_W'(i_req.payload.left_index);
        w_hi_in  = POS_W'(i_req.payload.right_index);
        w_size   = POS_W'(r_size);
        w_limit  = (w_size < POS_DEPTH) ? w_size : POS_DEPTH;
        w_bad_in = (w_lo_in == '0) || (w_lo_in > w_hi_in) || (w_hi_in > w_limit);
    end

    // Tree walk helpers
    assign w_lo_ext  = POS_W'(r_lo);
    assign w_hi_ext  = POS_W'(r_hi);
    assign w_low_bit = r_pos & (~r_pos + POS_W'(1));
    assign w_addr    = ADDR_W'(r_pos - POS_W'(1));
    assign w_neg_val = ~r_val + SUM_W'(1);

    // Shared multiplier: one 32-bit half of the 64-bit operand per step
    assign w_mul_half = (w_op == OP_MUL_HI) ? r_mul_a[SUM_W-1:HALF_W] : r_mul_a[HALF_W-1:0];
    assign w_mul_p    = {{POS_W{1'b0}}, w_mul_half} * {{HALF_W{1'b0}}, r_mul_b};

    // Tree memories
    assign w_we      = (w_op == OP_CLEAR) || (w_op == OP_UPD_WR);
    assign w_wdata_s = (w_op == OP_CLEAR) ? '0 : w_rd_s + r_amt_s;
    assign w_wdata_o = (w_op == OP_CLEAR) ? '0 : w_rd_o + r_amt_o;

    rarsf_ram #(
        .WIDTH (SUM_W),
        .DEPTH (DEPTH)
    ) u_slope_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_addr),
        .i_wdata (w_wdata_s),
        .i_raddr (w_addr),
        .o_rdata (w_rd_s)
    );

    rarsf_ram #(
        .WIDTH (SUM_W),
        .DEPTH (DEPTH)
    ) u_offset_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_addr),
        .i_wdata (w_wdata_o),
        .i_raddr (w_addr),
        .o_rdata (w_rd_o)
    );

    // Status back to the sequencer
    always_comb begin
        w_stat.req_valid = i_req.valid;
        w_stat.clr_more  = (r_pos != POS_DEPTH);
        w_stat.add_bad   = r_bad && (r_cmd == CMD_ADD);
        w_stat.range_bad = r_bad;
        w_stat.is_sum    = (r_cmd == CMD_SUM);
        w_stat.pos_out   = (r_pos == '0) || (r_pos > POS_DEPTH);
        w_stat.pos_zero  = (r_pos == '0);
        w_stat.out_busy  = r_out_valid && !o_rsp.ready;
    end

    assign w_emit = (w_op == OP_EMIT) && !w_stat.out_busy;

    // Control registers: size, walk position, response valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size      <= SIZE_RST;
            r_pos       <= POS_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_size <= i_cfg.payload.size_in_use;
            end
            unique case (w_op)
                OP_CLEAR:               r_pos <= r_pos + POS_W'(1);
                OP_ADD_LEFT:            r_pos <= w_lo_ext;
                OP_ADD_RIGHT:           r_pos <= w_hi_ext + POS_W'(1);
                OP_UPD_WR:              r_pos <= r_pos + w_low_bit;
                OP_SUM_HI:              r_pos <= w_hi_ext;
                OP_SUM_LO:              r_pos <= w_lo_ext - POS_W'(1);
                OP_QRY_ACC:             r_pos <= r_pos - w_low_bit;
                default:                r_pos <= r_pos;
            endcase
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        unique case (w_op)
            OP_TAKE: begin
                if (i_req.valid) begin
                    r_cmd <= i_req.payload.command;
                    r_lo  <= i_req.payload.left_index;
                    r_hi  <= i_req.payload.right_index;
                    r_val <= {{(SUM_W-VAL_W){i_req.payload.add_value[VAL_W-1]}},
                              i_req.payload.add_value};
                    r_bad <= w_bad_in;
                end
            end
            OP_ADD_LEFT: begin
                r_mul_a <= r_val;
                r_mul_b <= w_lo_ext - POS_W'(1);
                r_amt_s <= r_val;
            end
            OP_ADD_RIGHT: begin
                r_mul_a <= w_neg_val;
                r_mul_b <= w_hi_ext;
                r_amt_s <= w_neg_val;
            end
            OP_MUL_LO:   r_prod <= {{(SUM_W-PROD_W){1'b0}}, w_mul_p};
            OP_MUL_HI:   r_prod <= r_prod + {w_mul_p[HALF_W-1:0], {HALF_W{1'b0}}};
            OP_AMT_LOAD: r_amt_o <= r_prod;
            OP_SUM_HI: begin
                r_mul_b <= w_hi_ext;
                r_acc_s <= '0;
                r_acc_o <= '0;
            end
            OP_SUM_LO: begin
                r_mul_b <= w_lo_ext - POS_W'(1);
                r_acc_s <= '0;
                r_acc_o <= '0;
            end
            OP_QRY_ACC: begin
                r_acc_s <= r_acc_s + w_rd_s;
                r_acc_o <= r_acc_o + w_rd_o;
            end
            OP_SET_MA: r_mul_a <= r_acc_s;
            OP_SUM_FIRST: begin
                r_result <= r_prod - r_acc_o;
                r_err    <= 1'b0;
            end
            OP_SUM_SECOND: r_result <= r_result - (r_prod - r_acc_o);
            OP_SET_ERR: begin
                r_result <= '0;
                r_err    <= 1'b1;
            end
            default: begin
            end
        endcase
        // Load the response register
        if (w_emit) begin
            r_out.range_sum   <= r_result;
            r_out.range_error <= r_err;
        end
    end

    // Ports
    assign i_req.ready   = (w_op == OP_TAKE);
    assign i_cfg.ready   = 1'b1;
    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;
endmodule

### hdl/rarsf_ram.sv
module rarsf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### hdl/rarsf_useq.sv
module rarsf_useq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rarsf_pkg::t_seq_stat  i_stat,
    output rarsf_pkg::t_uop       o_op
);
    import rarsf_pkg::*;

    t_upc   r_pc;
    t_upc   n_pc;
    t_uword w_uword;
    logic   w_jump;

    // Step counter; start with the memory clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= U_CLEAR;
        end else begin
            r_pc <= n_pc;
        end
    end

    // Fetch the control word and resolve the jump
    always_comb begin
        w_uword = ucode_rom(r_pc);
        unique case (w_uword.cond)
            C_NEVER:     w_jump = 1'b0;
            C_ALWAYS:    w_jump = 1'b1;
            C_NO_REQ:    w_jump = !i_stat.req_valid;
            C_CLR_MORE:  w_jump = i_stat.clr_more;
            C_ADD_BAD:   w_jump = i_stat.add_bad;
            C_RANGE_BAD: w_jump = i_stat.range_bad;
            C_IS_SUM:    w_jump = i_stat.is_sum;
            C_POS_OUT:   w_jump = i_stat.pos_out;
            C_POS_ZERO:  w_jump = i_stat.pos_zero;
            C_OUT_BUSY:  w_jump = i_stat.out_busy;
            default:     w_jump = 1'b0;
        endcase
        n_pc = w_jump ? w_uword.target : t_upc'(r_pc + UPC_W'(1));
        o_op = w_uword.op;
    end
endmodule

### hdl/rarsf_chk.sv
module rarsf_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_req_valid,
    input logic                        i_req_ready,
    input logic                        i_rsp_valid,
    input logic                        i_rsp_ready,
    input logic [rarsf_pkg::SUM_W-1:0] i_rsp_sum,
    input logic                        i_rsp_err
);
    import rarsf_pkg::*;

    // Hold a stalled response
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_sum) && $stable(i_rsp_err))
        else $error("response changed while stalled");

    // Error responses carry a zero sum
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_err |-> (i_rsp_sum == '0))
        else $error("error response with nonzero sum");

    // Not ready for a request when reset is first released, as the clearing pass starts
    a_clear_busy: assert property (@(posedge i_clk)
        i_rst_n && !$past(i_rst_n) |-> !i_req_ready)
        else $error("request ready during clearing pass");

    // One request at a time: no back-to-back accept
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request ready right after accept");

    // A response never shows up the cycle after a request is taken
    a_no_instant_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !$rose(i_rsp_valid))
        else $error("response rose right after accept");
endmodule

bind range_add_range_sum_fenwick rarsf_chk u_rarsf_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_sum   (o_rsp.payload.range_sum),
    .i_rsp_err   (o_rsp.payload.range_error)
);

### tb/rarsf_sum_checker.sv
`timescale 1ns / 1ps

module rarsf_sum_checker #(
    parameter int DEPTH = 4096
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    input  logic            i_req_ready,
    input  rarsf_pkg::t_req i_req,
    input  logic            i_rsp_valid,
    input  logic            i_rsp_ready,
    input  rarsf_pkg::t_rsp i_rsp,
    input  logic            i_cfg_valid,
    input  logic            i_cfg_ready,
    input  rarsf_pkg::t_cfg i_cfg,
    output int              o_fail_count,
    output int              o_pending
);
    import rarsf_pkg::*;

    localparam bit SLOPE  = 1'b0;
    localparam bit OFFSET = 1'b1;

    // Shadow copy of both trees and the size register
    logic [63:0]      slope_bit  [1:DEPTH];
    logic [63:0]      offset_bit [1:DEPTH];
    logic [IDX_W-1:0] size_now;
    t_rsp             expected_sums [$];
    int               fail_total = 0;

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        $display("mismatch at %0t ns: %s got %h expected %h", $time, what, got, want);
        fail_total++;
    endtask

    // Point update, walking up to the tree root
    function automatic void tree_add(input bit sel, input int unsigned pos,
                                     input logic [63:0] amt);
        while (pos >= 1 && pos <= DEPTH) begin
            if (sel == OFFSET) offset_bit[pos] += amt;
            else               slope_bit[pos]  += amt;
            pos += pos & (~pos + 1);
        end
    endfunction

    function automatic logic [63:0] tree_prefix(input bit sel, input int unsigned pos);
        logic [63:0] acc;
        acc = '0;
        if (pos > DEPTH) pos = DEPTH;
        while (pos != 0) begin
            acc += (sel == OFFSET) ? offset_bit[pos] : slope_bit[pos];
            pos -= pos & (~pos + 1);
        end
        return acc;
    endfunction

    // Sum of elements one to b
    function automatic logic [63:0] prefix_total(input int unsigned b);
        return tree_prefix(SLOPE, b) * 64'(b) - tree_prefix(OFFSET, b);
    endfunction

    // Update the trees for an add, or queue the expected sum
    function automatic void apply_request(input t_req r);
        logic [63:0] amt;
        int unsigned lo, hi, lim;
        bit          ok;
        t_rsp        res;
        lo  = r.left_index;
        hi  = r.right_index;
        lim = (size_now < DEPTH) ? size_now : DEPTH;
        ok  = lo >= 1 && lo <= hi && hi <= lim;
        amt = {{(64-VAL_W){r.add_value[VAL_W-1]}}, r.add_value};
        if (r.command == CMD_ADD) begin
            if (ok) begin
                tree_add(SLOPE, lo, amt);
                tree_add(SLOPE, hi + 1, 64'd0 - amt);
                tree_add(OFFSET, lo, amt * 64'(lo - 1));
                tree_add(OFFSET, hi + 1, (64'd0 - amt) * 64'(hi));
            end
        end else begin
            res.range_sum   = ok ? prefix_total(hi) - prefix_total(lo - 1) : '0;
            res.range_error = !ok;
            expected_sums.push_back(res);
        end
    endfunction

    // Watch all three channels; compare responses before taking new requests
    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            for (int k = 1; k <= DEPTH; k++) begin
                slope_bit[k]  = '0;
                offset_bit[k] = '0;
            end
            size_now = SIZE_RST;
            expected_sums.delete();
        end else begin
            if (i_rsp_valid && i_rsp_ready) begin
                if (expected_sums.size() == 0) begin
                    flag_mismatch("unexpected response", i_rsp.range_sum, '0);
                end else begin
                    want = expected_sums.pop_front();
                    if (i_rsp.range_sum !== want.range_sum)
                        flag_mismatch("range_sum", i_rsp.range_sum, want.range_sum);
                    if (i_rsp.range_error !== want.range_error)
                        flag_mismatch("range_error", 64'(i_rsp.range_error),
                                      64'(want.range_error));
                end
            end
            if (i_cfg_valid && i_cfg_ready) size_now = i_cfg.size_in_use;
            if (i_req_valid && i_req_ready) apply_request(i_req);
        end
        o_pending    <= expected_sums.size();
        o_fail_count <= fail_total;
    end

endmodule

### tb/tb_range_add_range_sum_fenwick.sv
`timescale 1ns / 1ps

module tb_range_add_range_sum_fenwick;
    import rarsf_pkg::*;

    localparam int DEPTH        = 4096;
    localparam int DRAIN_CYCLES = 100;

    logic i_clk;
    logic i_rst_n;
    bit   calm = 1'b0;
    int   fail_count;
    int   pending;

    rarsf_chan_if #(.T_PAYLOAD(t_req)) req_if ();
    rarsf_chan_if #(.T_PAYLOAD(t_rsp)) rsp_if ();
    rarsf_chan_if #(.T_PAYLOAD(t_cfg)) cfg_if ();

    range_add_range_sum_fenwick #(.DEPTH(DEPTH)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    rarsf_sum_checker #(.DEPTH(DEPTH)) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (req_if.valid),
        .i_req_ready  (req_if.ready),
        .i_req        (req_if.payload),
        .i_rsp_valid  (rsp_if.valid),
        .i_rsp_ready  (rsp_if.ready),
        .i_rsp        (rsp_if.payload),
        .i_cfg_valid  (cfg_if.valid),
        .i_cfg_ready  (cfg_if.ready),
        .i_cfg        (cfg_if.payload),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Stall the response side at random, except in calm stretches
    initial begin
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            rsp_if.ready <= calm || ($urandom_range(0, 99) >= 23);
        end
    end

    // Hard stop for a hung run
    initial begin
        #20_000_000;
        $display("[range_add_range_sum_fenwick] ERROR");
        $finish;
    end

    function automatic t_req pack_req(input logic cmd, input int unsigned lo,
                                      input int unsigned hi, input logic [31:0] val);
        t_req r;
        r.command     = cmd;
        r.left_index  = IDX_W'(lo);
        r.right_index = IDX_W'(hi);
        r.add_value   = val;
        return r;
    endfunction

    // Mostly well-formed ranges under the limit, the rest anywhere in the field
    function automatic t_req random_request(input int lim);
        t_req        r;
        int unsigned a, b, roll;
        r.command = $urandom_range(0, 1) ? CMD_SUM : CMD_ADD;
        roll = $urandom_range(0, 99);
        if (roll < 5)       r.add_value = 32'h8000_0000;
        else if (roll < 10) r.add_value = 32'h7fff_ffff;
        else if (roll < 20) r.add_value = 32'($urandom_range(0, 15)) - 32'd8;
        else                r.add_value = $urandom;
        if (lim > 0 && $urandom_range(0, 99) < 88) begin
            a = $urandom_range(1, lim);
            if ($urandom_range(0, 99) < 30) begin
                b = a + $urandom_range(0, 7);
                if (b > lim) b = lim;
            end else begin
                b = $urandom_range(1, lim);
            end
            if (a > b) begin
                r.left_index  = IDX_W'(b);
                r.right_index = IDX_W'(a);
            end else begin
                r.left_index  = IDX_W'(a);
                r.right_index = IDX_W'(b);
            end
        end else begin
            r.left_index  = IDX_W'($urandom_range(0, (1 << IDX_W) - 1));
            r.right_index = IDX_W'($urandom_range(0, (1 << IDX_W) - 1));
        end
        return r;
    endfunction

    // Present one request, idling first at random; valid stays up after accept
    task automatic send_request(input t_req r);
        while (!calm && $urandom_range(0, 99) < 23) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid   <= 1'b1;
        req_if.payload <= r;
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    // Drop valid, wait for every expected sum, then let a trailing add finish
    task automatic drain();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_size(input int unsigned size);
        cfg_if.valid                   <= 1'b1;
        cfg_if.payload.size_in_use     <= IDX_W'(size);
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Random requests; ignored adds are not counted; pause once midway
    task automatic run_random(input int count, input int lim);
        t_req r;
        int   done;
        bit   paused;
        done   = 0;
        paused = 1'b0;
        while (done < count) begin
            r = random_request(lim);
            send_request(r);
            if (r.command == CMD_SUM || (r.left_index >= 1 &&
                r.left_index <= r.right_index && r.right_index <= lim))
                done++;
            if (!paused && done >= count / 2) begin
                paused = 1'b1;
                drain();
            end
        end
    endtask

    task automatic run_phase(input int unsigned size, input int count);
        drain();
        write_size(size);
        run_random(count, (size < DEPTH) ? size : DEPTH);
    endtask

    initial begin
        int unsigned mid_size;
        i_rst_n         <= 1'b0;
        req_if.valid    <= 1'b0;
        req_if.payload  <= '0;
        cfg_if.valid    <= 1'b0;
        cfg_if.payload  <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: full span, extreme values, single elements, bad ranges
        send_request(pack_req(CMD_SUM, 1, 4096, 32'h0));
        send_request(pack_req(CMD_ADD, 1, 4096, 32'h7fff_ffff));
        send_request(pack_req(CMD_ADD, 1, 4096, 32'h8000_0000));
        send_request(pack_req(CMD_ADD, 1, 1, 32'hffff_ffff));
        send_request(pack_req(CMD_ADD, 4096, 4096, 32'h1234_5678));
        send_request(pack_req(CMD_ADD, 0, 5, 32'h0000_0100));
        send_request(pack_req(CMD_ADD, 9, 3, 32'h0000_0100));
        send_request(pack_req(CMD_ADD, 1, 4097, 32'h0000_0100));
        send_request(pack_req(CMD_ADD, 8191, 8191, 32'h0000_0100));
        send_request(pack_req(CMD_SUM, 1, 4096, 32'h0));
        send_request(pack_req(CMD_SUM, 1, 1, 32'hffff_ffff));
        send_request(pack_req(CMD_SUM, 4096, 4096, 32'h0));
        send_request(pack_req(CMD_SUM, 0, 10, 32'h0));
        send_request(pack_req(CMD_SUM, 10, 9, 32'h0));
        send_request(pack_req(CMD_SUM, 1, 4097, 32'h0));
        send_request(pack_req(CMD_SUM, 8191, 8191, 32'h0));
        send_request(pack_req(CMD_ADD, 100, 3000, 32'h0000_0001));
        send_request(pack_req(CMD_SUM, 99, 101, 32'h0));
        send_request(pack_req(CMD_SUM, 2048, 4096, 32'h0));
        send_request(pack_req(CMD_SUM, 5, 5, 32'h0));

        // Random phases over several sizes, extremes included
        run_phase(1, 120);
        run_phase(0, 40);
        drain();
        write_size(8191);
        calm = 1'b1;
        run_random(200, DEPTH);
        calm = 1'b0;
        run_random(250, DEPTH);
        run_phase(37, 300);
        run_phase(2, 100);
        mid_size = $urandom_range(3, DEPTH - 1);
        run_phase(mid_size, 350);
        run_phase(DEPTH, 340);
        drain();

        if (fail_count == 0 && pending == 0) begin
            $display("[range_add_range_sum_fenwick] OK");
        end else begin
            $display("[range_add_range_sum_fenwick] ERROR");
        end
        $finish;
    end

endmodule

### sim.f
hdl/rarsf_pkg.sv
hdl/rarsf_chan_if.sv
hdl/rarsf_ram.sv
hdl/rarsf_useq.sv
hdl/range_add_range_sum_fenwick.sv
hdl/rarsf_chk.sv
tb/rarsf_sum_checker.sv
tb/tb_range_add_range_sum_fenwick.sv
